### src/hsv2rgb_pkg.sv
// Shared types, constants and sector codes for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CHAN_W = 8;
  localparam int HMOD_W = 6;
  localparam int PROD_W = 14;   // (100 - S) * V, up to 10000
  localparam int RPROD_W = 13;  // (V - min) * (hue mod 60), up to 5900

  localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam int SECTOR_DEG = 60;

  // x / 100 for x < 2^14 as (x * 5243) >> 19
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_100_SH = 19;
  // x / 60 for x <= 5900 as (x * 17477) >> 20
  localparam logic [14:0] RECIP_60 = 15'd17477;
  localparam int RECIP_60_SH = 20;
  // L * 255 / 100 as (L * 1336965) >> 19
  localparam logic [20:0] SCALE_MUL = 21'd1336965;
  localparam int SCALE_SH = 19;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Front end result: sector, offset in sector and min level
  typedef struct packed {
    logic               err;
    sector_t            sector;
    logic [HMOD_W-1:0]  hmod;
    logic [PCT_W-1:0]   val;
    logic [PCT_W-1:0]   vmin;
    logic [PCT_W-1:0]   diff;
  } front_t;

  // Channel levels in percent before scaling
  typedef struct packed {
    logic              err;
    logic [PCT_W-1:0]  red;
    logic [PCT_W-1:0]  green;
    logic [PCT_W-1:0]  blue;
  } level_t;

endpackage

### src/hsv2rgb_front.sv
// Range check, sector split and minimum level (two register stages).
module hsv2rgb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     sat,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     val,
  output logic                              out_vld,
  output hsv2rgb_pkg::front_t               out_data
);

  // stage 1
  logic                               s1_vld_r;
  logic                               s1_err_r;
  hsv2rgb_pkg::sector_t               s1_sector_r;
  logic [hsv2rgb_pkg::HMOD_W-1:0]     s1_hmod_r;
  logic [hsv2rgb_pkg::PROD_W-1:0]     s1_prod_r;
  logic [hsv2rgb_pkg::PCT_W-1:0]      s1_val_r;

  hsv2rgb_pkg::sector_t               sector_nxt;
  logic [hsv2rgb_pkg::HUE_W-1:0]      base_nxt;
  logic [hsv2rgb_pkg::HUE_W-1:0]      hoff_nxt;
  logic [hsv2rgb_pkg::PCT_W-1:0]      inv_sat;
  logic                               err_nxt;

  // stage 2
  logic                               s2_vld_r;
  hsv2rgb_pkg::front_t                s2_data_r;
  logic [hsv2rgb_pkg::PROD_W+12:0]    vmin_mul;
  logic [hsv2rgb_pkg::PCT_W-1:0]      vmin_nxt;

  assign err_nxt = (hue > hsv2rgb_pkg::HUE_MAX) || (sat > hsv2rgb_pkg::PCT_MAX) ||
                   (val > hsv2rgb_pkg::PCT_MAX);
  assign inv_sat = hsv2rgb_pkg::PCT_MAX - sat;

  // 360 wraps to sector 0 with zero offset
  always_comb begin
    priority if (hue >= 9'd360) begin
      sector_nxt = hsv2rgb_pkg::SEC_RED_YEL;
      base_nxt   = 9'd360;
    end else if (hue >= 9'd300) begin
      sector_nxt = hsv2rgb_pkg::SEC_MAG_RED;
      base_nxt   = 9'd300;
    end else if (hue >= 9'd240) begin
      sector_nxt = hsv2rgb_pkg::SEC_BLU_MAG;
      base_nxt   = 9'd240;
    end else if (hue >= 9'd180) begin
      sector_nxt = hsv2rgb_pkg::SEC_CYN_BLU;
      base_nxt   = 9'd180;
    end else if (hue >= 9'd120) begin
      sector_nxt = hsv2rgb_pkg::SEC_GRN_CYN;
      base_nxt   = 9'd120;
    end else if (hue >= 9'd60) begin
      sector_nxt = hsv2rgb_pkg::SEC_YEL_GRN;
      base_nxt   = 9'd60;
    end else begin
      sector_nxt = hsv2rgb_pkg::SEC_RED_YEL;
      base_nxt   = 9'd0;
    end
  end

  assign hoff_nxt = hue - base_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_err_r    <= err_nxt;
    s1_sector_r <= sector_nxt;
    s1_hmod_r   <= hoff_nxt[hsv2rgb_pkg::HMOD_W-1:0];
    s1_prod_r   <= hsv2rgb_pkg::PROD_W'(inv_sat * val);
    s1_val_r    <= val;
  end

  assign vmin_mul = {13'd0, s1_prod_r} * {{hsv2rgb_pkg::PROD_W{1'b0}}, hsv2rgb_pkg::RECIP_100};
  assign vmin_nxt = vmin_mul[hsv2rgb_pkg::RECIP_100_SH +: hsv2rgb_pkg::PCT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_data_r.err    <= s1_err_r;
    s2_data_r.sector <= s1_sector_r;
    s2_data_r.hmod   <= s1_hmod_r;
    s2_data_r.val    <= s1_val_r;
    s2_data_r.vmin   <= vmin_nxt;
    s2_data_r.diff   <= s1_val_r - vmin_nxt;
  end

  assign out_vld  = s2_vld_r;
  assign out_data = s2_data_r;

endmodule

### src/hsv2rgb_ramp.sv
// Ramp product, ramp divide and sector multiplexer (two register stages).
module hsv2rgb_ramp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  hsv2rgb_pkg::front_t  in_data,
  output logic                 out_vld,
  output hsv2rgb_pkg::level_t  out_data
);

  logic                                s3_vld_r;
  hsv2rgb_pkg::front_t                 s3_data_r;
  logic [hsv2rgb_pkg::RPROD_W-1:0]     s3_rprod_r;

  logic                                s4_vld_r;
  hsv2rgb_pkg::level_t                 s4_data_r;

  logic [hsv2rgb_pkg::RPROD_W+14:0]    ramp_mul;
  logic [hsv2rgb_pkg::PCT_W-1:0]       ramp;
  logic [hsv2rgb_pkg::PCT_W-1:0]       rise;
  logic [hsv2rgb_pkg::PCT_W-1:0]       fall;
  hsv2rgb_pkg::level_t                 lvl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= in_vld;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_data_r  <= in_data;
    s3_rprod_r <= hsv2rgb_pkg::RPROD_W'(in_data.diff * in_data.hmod);
  end

  assign ramp_mul = {15'd0, s3_rprod_r} * {{hsv2rgb_pkg::RPROD_W{1'b0}}, hsv2rgb_pkg::RECIP_60};
  assign ramp = ramp_mul[hsv2rgb_pkg::RECIP_60_SH +: hsv2rgb_pkg::PCT_W];
  assign rise = s3_data_r.vmin + ramp;
  assign fall = s3_data_r.val - ramp;

  always_comb begin
    lvl_nxt.err = s3_data_r.err;
    unique case (s3_data_r.sector)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        lvl_nxt.red = s3_data_r.val;  lvl_nxt.green = rise;  lvl_nxt.blue = s3_data_r.vmin;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        lvl_nxt.red = fall;  lvl_nxt.green = s3_data_r.val;  lvl_nxt.blue = s3_data_r.vmin;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        lvl_nxt.red = s3_data_r.vmin;  lvl_nxt.green = s3_data_r.val;  lvl_nxt.blue = rise;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        lvl_nxt.red = s3_data_r.vmin;  lvl_nxt.green = fall;  lvl_nxt.blue = s3_data_r.val;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        lvl_nxt.red = rise;  lvl_nxt.green = s3_data_r.vmin;  lvl_nxt.blue = s3_data_r.val;
      end
      default: begin
        lvl_nxt.red = s3_data_r.val;  lvl_nxt.green = s3_data_r.vmin;  lvl_nxt.blue = fall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s4_data_r <= lvl_nxt;
  end

  assign out_vld  = s4_vld_r;
  assign out_data = s4_data_r;

endmodule

### src/hsv2rgb_scale.sv
// Percent to 8-bit channel scaling and error clamp (output register stage).
module hsv2rgb_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  hsv2rgb_pkg::level_t                in_data,
  output logic                               out_vld,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     blue,
  output logic                               err
);

  localparam int MUL_W = hsv2rgb_pkg::PCT_W + 21;

  logic                               vld_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]     red_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]     green_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]     blue_r;
  logic                               err_r;

  logic [MUL_W-1:0] red_mul;
  logic [MUL_W-1:0] green_mul;
  logic [MUL_W-1:0] blue_mul;

  assign red_mul   = MUL_W'(in_data.red)   * MUL_W'(hsv2rgb_pkg::SCALE_MUL);
  assign green_mul = MUL_W'(in_data.green) * MUL_W'(hsv2rgb_pkg::SCALE_MUL);
  assign blue_mul  = MUL_W'(in_data.blue)  * MUL_W'(hsv2rgb_pkg::SCALE_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // drop channels to zero on a range error
  always_ff @(posedge clk) begin
    err_r <= in_data.err;
    if (in_data.err) begin
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
    end else begin
      red_r   <= red_mul[hsv2rgb_pkg::SCALE_SH +: hsv2rgb_pkg::CHAN_W];
      green_r <= green_mul[hsv2rgb_pkg::SCALE_SH +: hsv2rgb_pkg::CHAN_W];
      blue_r  <= blue_mul[hsv2rgb_pkg::SCALE_SH +: hsv2rgb_pkg::CHAN_W];
    end
  end

  assign out_vld = vld_r;
  assign red     = red_r;
  assign green   = green_r;
  assign blue    = blue_r;
  assign err     = err_r;

endmodule

### src/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to 8-bit RGB converter.
//
//  channel  | ports                                       | handshake
//  ---------+---------------------------------------------+-------------------------
//  input    | in_hue, in_saturation, in_brightness        | start high, busy low
//  result   | out_red, out_green, out_blue,               | out_valid for one cycle
//           | out_out_of_range                            |
//
// Five register stages; one request accepted every cycle.
// Each stage registers a multiply: (100 - S) * V, the reciprocal divide by 100,
// the ramp product, the reciprocal divide by 60 and the channel scaling.
// busy stays low; valid bits travel with the data and the result strobe cannot stall.
// Synchronous reset clears the valid bits only; requests in flight are dropped.
module hsv_to_rgb_converter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]      in_hue,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]      in_saturation,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]      in_brightness,
  output logic                               out_valid,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     out_red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     out_green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     out_blue,
  output logic                               out_out_of_range
);

  logic                 accept;
  logic                 front_vld;
  hsv2rgb_pkg::front_t  front_data;
  logic                 lvl_vld;
  hsv2rgb_pkg::level_t  lvl_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  hsv2rgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .hue      (in_hue),
    .sat      (in_saturation),
    .val      (in_brightness),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  hsv2rgb_ramp u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (front_vld),
    .in_data  (front_data),
    .out_vld  (lvl_vld),
    .out_data (lvl_data)
  );

  hsv2rgb_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (lvl_vld),
    .in_data (lvl_data),
    .out_vld (out_valid),
    .red     (out_red),
    .green   (out_green),
    .blue    (out_blue),
    .err     (out_out_of_range)
  );

  // every accepted request comes out with out_valid set
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("result missing five cycles after request");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result without a matching request");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("range error with nonzero channels");

  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_hue > hsv2rgb_pkg::HUE_MAX || in_saturation > hsv2rgb_pkg::PCT_MAX ||
                in_brightness > hsv2rgb_pkg::PCT_MAX)) |-> ##5 out_out_of_range)
    else $error("out of range request not flagged");

endmodule

### dv/hsv_to_rgb_checker.sv
// Request/result monitor and scoreboard for the HSV to RGB converter.
module hsv_to_rgb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]  in_hue,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]  in_saturation,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]  in_brightness,
  input  logic                           out_valid,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] out_red,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] out_green,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0] out_blue,
  input  logic                           out_out_of_range,
  output int                             failures,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int unsigned SECTOR_COUNT = 6;
  localparam int unsigned CHAN_FULL = 255;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              out_of_range;
  } rgb_color_t;

  rgb_color_t expected_colors[$];
  int         mismatch_count;

  function automatic logic [CHAN_W-1:0] to_channel(input int unsigned level);
    return CHAN_W'((level * CHAN_FULL) / PCT_MAX);
  endfunction

  function automatic rgb_color_t convert_hsv(input logic [HUE_W-1:0] hue,
                                             input logic [PCT_W-1:0] sat,
                                             input logic [PCT_W-1:0] val);
    int unsigned h, s, v, floor_lvl, ramp, rise, fall, r, g, b;
    sector_t     sec;
    rgb_color_t  color;
    color = '0;
    h = hue;
    s = sat;
    v = val;
    if (h > HUE_MAX || s > PCT_MAX || v > PCT_MAX) begin
      color.out_of_range = 1'b1;
      return color;
    end
    // hue 360 wraps back into the red-yellow sector
    sec = sector_t'((h / SECTOR_DEG) % SECTOR_COUNT);
    floor_lvl = ((PCT_MAX - s) * v) / PCT_MAX;
    ramp = ((v - floor_lvl) * (h % SECTOR_DEG)) / SECTOR_DEG;
    rise = floor_lvl + ramp;
    fall = v - ramp;
    case (sec)
      SEC_RED_YEL: begin r = v;         g = rise;      b = floor_lvl; end
      SEC_YEL_GRN: begin r = fall;      g = v;         b = floor_lvl; end
      SEC_GRN_CYN: begin r = floor_lvl; g = v;         b = rise;      end
      SEC_CYN_BLU: begin r = floor_lvl; g = fall;      b = v;         end
      SEC_BLU_MAG: begin r = rise;      g = floor_lvl; b = v;         end
      default: begin     r = v;         g = floor_lvl; b = fall;      end
    endcase
    color.red = to_channel(r);
    color.green = to_channel(g);
    color.blue = to_channel(b);
    return color;
  endfunction

  always @(posedge clk) begin
    rgb_color_t got, want;
    if (rst_n) begin
      if (start && !busy) begin
        expected_colors.push_back(convert_hsv(in_hue, in_saturation, in_brightness));
      end
      if (out_valid === 1'b1) begin
        got = '{out_red, out_green, out_blue, out_out_of_range};
        if (expected_colors.size() == 0) begin
          $display("%0t: result with no request pending, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red) begin
            $display("%0t: red expected %0d, got %0d", $time, want.red, got.red);
            mismatch_count++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %0d, got %0d", $time, want.green, got.green);
            mismatch_count++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d, got %0d", $time, want.blue, got.blue);
            mismatch_count++;
          end
          if (got.out_of_range !== want.out_of_range) begin
            $display("%0t: out_of_range expected %0b, got %0b", $time,
                     want.out_of_range, got.out_of_range);
            mismatch_count++;
          end
        end
      end
    end
    failures <= mismatch_count;
    pending <= expected_colors.size();
  end

endmodule

### dv/hsv_to_rgb_converter_tb.sv
// Stimulus, clock, reset and verdict for the HSV to RGB converter.
module hsv_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int RANDOM_COLORS = 850;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [HUE_W-1:0]   in_hue;
  logic [PCT_W-1:0]   in_saturation;
  logic [PCT_W-1:0]   in_brightness;
  logic               out_valid;
  logic [CHAN_W-1:0]  out_red;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_blue;
  logic               out_out_of_range;
  int                 failures;
  int                 pending;
  int                 cycle_count = 0;
  bit                 no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hsv_to_rgb_converter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_hue           (in_hue),
    .in_saturation    (in_saturation),
    .in_brightness    (in_brightness),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_out_of_range (out_out_of_range)
  );

  hsv_to_rgb_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_hue           (in_hue),
    .in_saturation    (in_saturation),
    .in_brightness    (in_brightness),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_out_of_range (out_out_of_range),
    .failures         (failures),
    .pending          (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hsv_to_rgb_converter_tb failed");
      $finish;
    end
  end

  // Present one request, hold it until accepted, then idle for a random gap, possibly none.
  task automatic send_color(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                            input logic [PCT_W-1:0] val);
    int pick, gap;
    in_hue <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int hues[] = '{0, 1, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360, 361, 511};
    int pick;
    no_idle = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_hue = '0;
    in_saturation = '0;
    in_brightness = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sector boundaries, full and empty levels, each limit just past valid
    foreach (hues[i]) send_color(HUE_W'(hues[i]), PCT_MAX, PCT_MAX);
    send_color(9'd200, 7'd0, PCT_MAX);
    send_color(9'd200, PCT_MAX, 7'd0);
    send_color(9'd0, 7'd0, 7'd0);
    send_color(9'd30, 7'd101, 7'd50);
    send_color(9'd30, 7'd50, 7'd101);
    send_color(9'd511, 7'd127, 7'd127);
    send_color(9'd45, 7'd73, 7'd88);
    send_color(9'd333, 7'd1, 7'd99);

    for (int n = 0; n < RANDOM_COLORS; n++) begin
      // toggle stretches of back-to-back requests
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_color(HUE_W'($urandom_range(0, HUE_MAX)), PCT_W'($urandom_range(0, PCT_MAX)),
                   PCT_W'($urandom_range(0, PCT_MAX)));
      end else if (pick < 88) begin
        // levels near the ends of the range
        send_color(HUE_W'($urandom_range(0, HUE_MAX)),
                   ($urandom_range(0, 1) != 0) ? PCT_W'($urandom_range(95, 100))
                                               : PCT_W'($urandom_range(0, 5)),
                   ($urandom_range(0, 1) != 0) ? PCT_W'($urandom_range(95, 100))
                                               : PCT_W'($urandom_range(0, 5)));
      end else begin
        send_color(HUE_W'($urandom()), PCT_W'($urandom()), PCT_W'($urandom()));
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("hsv_to_rgb_converter_tb passed");
    end else begin
      $display("hsv_to_rgb_converter_tb failed");
    end
    $finish;
  end

endmodule

### files.f
src/hsv2rgb_pkg.sv
src/hsv2rgb_front.sv
src/hsv2rgb_ramp.sv
src/hsv2rgb_scale.sv
src/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_checker.sv
dv/hsv_to_rgb_converter_tb.sv
